// File: rtl/core/kalman_position_velocity_filter_core_defines.svh
// ----------------------------------------------------------------------------
// Kalman position/velocity filter core: assertion macros
// Shared property shorthands for the core's checks.
// ----------------------------------------------------------------------------
`ifndef KALMAN_POSITION_VELOCITY_FILTER_CORE_DEFINES_SVH
`define KALMAN_POSITION_VELOCITY_FILTER_CORE_DEFINES_SVH

// same-cycle implication
`define KPV_CHECK_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kpv check failed");

// next-cycle implication
`define KPV_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kpv check failed");

`endif

// File: rtl/core/kpv_pkg.sv
// ----------------------------------------------------------------------------
// kpv_pkg
// Types, operation codes and helpers of the Kalman filter core.
// ----------------------------------------------------------------------------
package kpv_pkg;

    localparam int ACC_W     = 56;
    localparam int DIV_STEPS = 48;

    localparam logic [3:0] MUL_NONE    = 4'd0;
    localparam logic [3:0] MUL_DT_DT   = 4'd1;
    localparam logic [3:0] MUL_DT_X1   = 4'd2;
    localparam logic [3:0] MUL_DT_2P01 = 4'd3;
    localparam logic [3:0] MUL_DT2_P11 = 4'd4;
    localparam logic [3:0] MUL_DT_P11  = 4'd5;
    localparam logic [3:0] MUL_K0_E    = 4'd6;
    localparam logic [3:0] MUL_K1_E    = 4'd7;
    localparam logic [3:0] MUL_OMK_A   = 4'd8;
    localparam logic [3:0] MUL_OMK_B   = 4'd9;
    localparam logic [3:0] MUL_K1_B    = 4'd10;

    localparam logic [3:0] WB_NONE = 4'd0;
    localparam logic [3:0] WB_DT2  = 4'd1;
    localparam logic [3:0] WB_XP   = 4'd2;
    localparam logic [3:0] WB_ACC  = 4'd3;
    localparam logic [3:0] WB_A    = 4'd4;
    localparam logic [3:0] WB_BCSE = 4'd5;
    localparam logic [3:0] WB_X0   = 4'd6;
    localparam logic [3:0] WB_X1   = 4'd7;
    localparam logic [3:0] WB_P00  = 4'd8;
    localparam logic [3:0] WB_P01  = 4'd9;
    localparam logic [3:0] WB_P11  = 4'd10;

    localparam logic [1:0] CFG_STEP_PERIOD    = 2'd0;
    localparam logic [1:0] CFG_POSITION_NOISE = 2'd1;
    localparam logic [1:0] CFG_VELOCITY_NOISE = 2'd2;
    localparam logic [1:0] CFG_MEASURE_NOISE  = 2'd3;

    typedef struct packed {
        logic [3:0] mul_sel;
        logic [3:0] wb_sel;
        logic       capture;
        logic       div_start;
        logic       load_out;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } status_t;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (v > ACC_W'(64'sd2147483647))
            r = 32'sh7FFFFFFF;
        else if (v < -ACC_W'(64'sd2147483648))
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [ACC_W-1:0] ext32(input logic signed [31:0] v);
        return {{(ACC_W-32){v[31]}}, v};
    endfunction

endpackage

// File: rtl/core/kpv_divider.sv
// ----------------------------------------------------------------------------
// kpv_divider
// Restoring divider for one gain: num*2^16/den, truncated, saturated.
// ----------------------------------------------------------------------------
module kpv_divider
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic               done,
    output logic signed [31:0] quo
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [47:0] dvd_reg, dvd_next;
    logic [31:0] dmag_reg, dmag_next;
    logic        neg_reg, neg_next;
    logic        zero_reg, zero_next;
    logic signed [31:0] quo_reg, quo_next;
    logic [32:0] rem_sh;
    logic        ge;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dmag_next = dmag_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        quo_next  = quo_reg;
        rem_sh    = {rem_reg, dvd_reg[47]};
        ge        = rem_sh >= {1'b0, dmag_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = {(num[31] ? (~num + 32'd1) : num), 16'd0};
            dmag_next = den[31] ? (~den + 32'd1) : den;
            neg_next  = num[31] ^ den[31];
            zero_next = (den == '0);
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 32'(rem_sh - {1'b0, dmag_reg}) : rem_sh[31:0];
            dvd_next = {dvd_reg[46:0], ge};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(kpv_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (zero_reg)
                    quo_next = '0;
                else if (neg_reg)
                    quo_next = (dvd_next > 48'h0000_8000_0000) ? 32'sh80000000
                                                               : -$signed(dvd_next[31:0]);
                else
                    quo_next = (dvd_next > 48'h0000_7FFF_FFFF) ? 32'sh7FFFFFFF
                                                               : $signed(dvd_next[31:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        dmag_reg <= dmag_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        quo_reg  <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// File: rtl/core/kpv_datapath.sv
// ----------------------------------------------------------------------------
// kpv_datapath
// Filter state, configuration, shared multiplier and gain dividers.
// ----------------------------------------------------------------------------
module kpv_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  kpv_pkg::cmd_t       cmd,
    output kpv_pkg::status_t    status,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [30:0]         cfg_data,
    input  logic signed [31:0]  measured_position,
    output logic signed [31:0]  est_position,
    output logic signed [31:0]  est_velocity,
    output logic signed [31:0]  innovation_value,
    output logic [30:0]         innovation_variance
);

    localparam int W = kpv_pkg::ACC_W;

    logic [16:0] dt_reg;
    logic [30:0] qp_reg, qv_reg, r_reg;
    logic signed [31:0] x0_reg, x1_reg, p00_reg, p01_reg, p11_reg;
    logic signed [31:0] z_reg, dt2_reg, xp_reg, a_reg, b_reg, c_reg, s_reg, e_reg;
    logic signed [W-1:0] acc_reg;
    logic signed [67:0] prod_reg;
    logic signed [33:0] opa, opb, dt_op, omk;
    logic signed [W-1:0] m;
    logic signed [31:0] k0, k1, sat_m, sat_p11;
    logic signed [31:0] pos_out_reg, vel_out_reg, inn_out_reg;
    logic [30:0] var_out_reg;
    logic done0, done1;

    kpv_divider u_div0
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (a_reg),
        .den   (s_reg),
        .done  (done0),
        .quo   (k0)
    );

    kpv_divider u_div1
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (b_reg),
        .den   (s_reg),
        .done  (done1),
        .quo   (k1)
    );

    assign status.div_done = done0 & done1;

    assign dt_op = {17'd0, dt_reg};
    assign omk   = 34'sd65536 - {{2{k0[31]}}, k0};

    always_comb
    begin
        case (cmd.mul_sel)
            kpv_pkg::MUL_DT_DT:   begin opa = dt_op; opb = dt_op; end
            kpv_pkg::MUL_DT_X1:   begin opa = dt_op; opb = {{2{x1_reg[31]}}, x1_reg}; end
            kpv_pkg::MUL_DT_2P01: begin opa = dt_op; opb = {p01_reg[31], p01_reg, 1'b0}; end
            kpv_pkg::MUL_DT2_P11:
            begin
                opa = {{2{dt2_reg[31]}}, dt2_reg};
                opb = {{2{p11_reg[31]}}, p11_reg};
            end
            kpv_pkg::MUL_DT_P11:  begin opa = dt_op; opb = {{2{p11_reg[31]}}, p11_reg}; end
            kpv_pkg::MUL_K0_E:
            begin
                opa = {{2{k0[31]}}, k0};
                opb = {{2{e_reg[31]}}, e_reg};
            end
            kpv_pkg::MUL_K1_E:
            begin
                opa = {{2{k1[31]}}, k1};
                opb = {{2{e_reg[31]}}, e_reg};
            end
            kpv_pkg::MUL_OMK_A:   begin opa = omk; opb = {{2{a_reg[31]}}, a_reg}; end
            kpv_pkg::MUL_OMK_B:   begin opa = omk; opb = {{2{b_reg[31]}}, b_reg}; end
            kpv_pkg::MUL_K1_B:
            begin
                opa = {{2{k1[31]}}, k1};
                opb = {{2{b_reg[31]}}, b_reg};
            end
            default:              begin opa = '0; opb = '0; end
        endcase
    end

    assign m       = {{(W-52){prod_reg[67]}}, prod_reg[67:16]};
    assign sat_m   = kpv_pkg::sat32(m);
    assign sat_p11 = kpv_pkg::sat32(kpv_pkg::ext32(c_reg) - m);

    always_ff @(posedge clk)
    begin
        prod_reg <= opa * opb;
        if (cmd.capture)
            z_reg <= measured_position;
        case (cmd.wb_sel)
            kpv_pkg::WB_DT2: dt2_reg <= sat_m;
            kpv_pkg::WB_XP:  xp_reg  <= kpv_pkg::sat32(kpv_pkg::ext32(x0_reg) + m);
            kpv_pkg::WB_ACC:
                acc_reg <= kpv_pkg::ext32(p00_reg) + {{(W-31){1'b0}}, qp_reg} + m;
            kpv_pkg::WB_A:   a_reg   <= kpv_pkg::sat32(acc_reg + m);
            kpv_pkg::WB_BCSE:
            begin
                b_reg <= kpv_pkg::sat32(kpv_pkg::ext32(p01_reg) + m);
                c_reg <= kpv_pkg::sat32(kpv_pkg::ext32(p11_reg)
                                        + {{(W-31){1'b0}}, qv_reg});
                s_reg <= kpv_pkg::sat32(kpv_pkg::ext32(a_reg) + {{(W-31){1'b0}}, r_reg});
                e_reg <= kpv_pkg::sat32(kpv_pkg::ext32(z_reg) - kpv_pkg::ext32(xp_reg));
            end
            default: ;
        endcase
        if (cmd.load_out)
        begin
            pos_out_reg <= x0_reg;
            vel_out_reg <= x1_reg;
            inn_out_reg <= e_reg;
            var_out_reg <= s_reg[31] ? 31'd0 : s_reg[30:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg  <= 17'd655;
            qp_reg  <= 31'd655;
            qv_reg  <= 31'd655;
            r_reg   <= 31'd65536;
            x0_reg  <= '0;
            x1_reg  <= '0;
            p00_reg <= 32'sd65536;
            p01_reg <= '0;
            p11_reg <= 32'sd65536;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    kpv_pkg::CFG_STEP_PERIOD:    dt_reg <= cfg_data[16:0];
                    kpv_pkg::CFG_POSITION_NOISE: qp_reg <= cfg_data;
                    kpv_pkg::CFG_VELOCITY_NOISE: qv_reg <= cfg_data;
                    kpv_pkg::CFG_MEASURE_NOISE:  r_reg  <= cfg_data;
                    default: ;
                endcase
            end
            case (cmd.wb_sel)
                kpv_pkg::WB_X0:  x0_reg  <= kpv_pkg::sat32(kpv_pkg::ext32(xp_reg) + m);
                kpv_pkg::WB_X1:  x1_reg  <= kpv_pkg::sat32(kpv_pkg::ext32(x1_reg) + m);
                kpv_pkg::WB_P00: p00_reg <= sat_m[31] ? 32'sd0 : sat_m;
                kpv_pkg::WB_P01: p01_reg <= sat_m;
                kpv_pkg::WB_P11: p11_reg <= sat_p11[31] ? 32'sd0 : sat_p11;
                default: ;
            endcase
        end
    end

    assign est_position        = pos_out_reg;
    assign est_velocity        = vel_out_reg;
    assign innovation_value    = inn_out_reg;
    assign innovation_variance = var_out_reg;

endmodule

// File: rtl/core/kpv_ctrl.sv
// ----------------------------------------------------------------------------
// kpv_ctrl
// Sequencer: predict, divide, update, deliver; drives the handshakes.
// ----------------------------------------------------------------------------
module kpv_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  kpv_pkg::status_t  status,
    output kpv_pkg::cmd_t     cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PRED  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_UPD   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;
    localparam logic [2:0] LAST_STEP = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.mul_sel    = kpv_pkg::MUL_NONE;
        cmd.wb_sel     = kpv_pkg::WB_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_PRED;
                    step_next   = '0;
                end
            end
            ST_PRED:
            begin
                case (step_reg)
                    3'd0: cmd.mul_sel = kpv_pkg::MUL_DT_DT;
                    3'd1: begin cmd.mul_sel = kpv_pkg::MUL_DT_X1;   cmd.wb_sel = kpv_pkg::WB_DT2; end
                    3'd2: begin cmd.mul_sel = kpv_pkg::MUL_DT_2P01; cmd.wb_sel = kpv_pkg::WB_XP;  end
                    3'd3: begin cmd.mul_sel = kpv_pkg::MUL_DT2_P11; cmd.wb_sel = kpv_pkg::WB_ACC; end
                    3'd4: begin cmd.mul_sel = kpv_pkg::MUL_DT_P11;  cmd.wb_sel = kpv_pkg::WB_A;   end
                    default: cmd.wb_sel = kpv_pkg::WB_BCSE;
                endcase
                step_next = step_reg + 3'd1;
                if (step_reg == LAST_STEP)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_UPD;
                    step_next  = '0;
                end
            end
            ST_UPD:
            begin
                case (step_reg)
                    3'd0: cmd.mul_sel = kpv_pkg::MUL_K0_E;
                    3'd1: begin cmd.mul_sel = kpv_pkg::MUL_K1_E;  cmd.wb_sel = kpv_pkg::WB_X0;  end
                    3'd2: begin cmd.mul_sel = kpv_pkg::MUL_OMK_A; cmd.wb_sel = kpv_pkg::WB_X1;  end
                    3'd3: begin cmd.mul_sel = kpv_pkg::MUL_OMK_B; cmd.wb_sel = kpv_pkg::WB_P00; end
                    3'd4: begin cmd.mul_sel = kpv_pkg::MUL_K1_B;  cmd.wb_sel = kpv_pkg::WB_P01; end
                    default: cmd.wb_sel = kpv_pkg::WB_P11;
                endcase
                step_next = step_reg + 3'd1;
                if (step_reg == LAST_STEP)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: rtl/core/kalman_position_velocity_filter_core.sv
// ----------------------------------------------------------------------------
// kalman_position_velocity_filter_core
// Two-state constant-velocity Kalman filter, signed Q16.16.
// ----------------------------------------------------------------------------
// One item at a time: an item is carried from acceptance to its result
// before the next one is accepted. The time is set by the 48-step gain
// dividers (both gains run side by side, with a done handoff) and ten passes
// through the one shared 34x34 multiplier. The input stalls while an item is
// in work; a finished result waits in the output register while the next
// item is accepted, and a result that is still held there when the next one
// is ready stalls the block until it is taken. Configuration writes take
// effect at once and belong to idle periods.
// ----------------------------------------------------------------------------
`include "kalman_position_velocity_filter_core_defines.svh"

module kalman_position_velocity_filter_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] measured_position,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] est_position,
    output logic signed [31:0] est_velocity,
    output logic signed [31:0] innovation_value,
    output logic [30:0]        innovation_variance,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [30:0]        cfg_data
);

    kpv_pkg::cmd_t    cmd;
    kpv_pkg::status_t status;

    kpv_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    kpv_datapath u_dp
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .status              (status),
        .cfg_write           (cfg_write),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .measured_position   (measured_position),
        .est_position        (est_position),
        .est_velocity        (est_velocity),
        .innovation_value    (innovation_value),
        .innovation_variance (innovation_variance)
    );

    `KPV_CHECK_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    `KPV_CHECK_NOW(a_result_from_work, $rose(out_valid), $past(in_stall))
    `KPV_CHECK_NOW(a_no_div_while_idle, !in_stall, !cmd.div_start && cmd.load_out == 1'b0)

endmodule

// File: test/tb_kalman_position_velocity_filter_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Kalman position/velocity filter core testbench
// Feeds position measurements through bursts, gaps and output stalls over a
// series of filter settings, and checks every result item against a
// fixed-point model of the predict and update step kept in this bench.
// ----------------------------------------------------------------------------
module tb_kalman_position_velocity_filter_core;

    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 235;

    typedef struct {
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [31:0] innov;
        logic [30:0]        var_s;
        bit                 innov_typed;
        logic signed [31:0] innov_given;
    } filter_out_t;

    typedef struct {
        logic signed [31:0] z;
        bit                 typed;
        logic signed [31:0] innov;
    } meas_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] measured_position;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] est_position;
    logic signed [31:0] est_velocity;
    logic signed [31:0] innovation_value;
    logic [30:0]        innovation_variance;
    logic               cfg_write;
    logic [1:0]         cfg_index;
    logic [30:0]        cfg_data;

    kalman_position_velocity_filter_core dut (.*);

    // filter model state
    logic [16:0]        m_dt;
    logic [30:0]        m_qp;
    logic [30:0]        m_qv;
    logic [30:0]        m_r;
    logic signed [31:0] m_x0;
    logic signed [31:0] m_x1;
    logic signed [31:0] m_p00;
    logic signed [31:0] m_p01;
    logic signed [31:0] m_p11;

    filter_out_t expected_q[$];
    bit          typed_next;
    logic signed [31:0] typed_innov;
    int          n_err;
    int          n_items;
    int          n_results;
    int          n_zero_s;
    int          cycle_count;
    int          holdoff;
    bit          holdoff_done;

    meas_row_t directed_rows[] = '{
        '{32'sh7FFFFFFF, 1'b1, 32'sh7FFFFFFF},
        '{32'sh80000000, 1'b0, 32'sd0},
        '{32'sd0,        1'b0, 32'sd0},
        '{32'sd65536,    1'b0, 32'sd0},
        '{-32'sd65536,   1'b0, 32'sd0},
        '{32'sh7FFFFFFF, 1'b0, 32'sd0},
        '{32'sh7FFFFFFF, 1'b0, 32'sd0},
        '{32'sh80000000, 1'b0, 32'sd0},
        '{32'sh80000000, 1'b0, 32'sd0},
        '{32'sd1,        1'b0, 32'sd0},
        '{-32'sd1,       1'b0, 32'sd0},
        '{32'sh55555555, 1'b0, 32'sd0},
        '{32'shAAAAAAAA, 1'b0, 32'sd0},
        '{32'sd131072,   1'b0, 32'sd0},
        '{32'sd196608,   1'b0, 32'sd0},
        '{32'sd262144,   1'b0, 32'sd0}
    };

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> 16;
    endfunction

    function automatic logic signed [31:0] kgain(longint num, longint den);
        if (den == 0)
            return 32'sd0;
        return clip32((num * 65536) / den);
    endfunction

    task automatic kalman_step(input logic signed [31:0] z);
        longint      dt;
        longint      dt2;
        longint      omk;
        logic signed [31:0] xp, a, b, c, s, k0, k1, e;
        filter_out_t r;
        dt  = longint'(m_dt);
        dt2 = qmul(dt, dt);
        xp  = clip32(longint'(m_x0) + qmul(dt, m_x1));
        a   = clip32(longint'(m_p00) + qmul(dt, 2 * longint'(m_p01))
                     + qmul(dt2, m_p11) + longint'(m_qp));
        b   = clip32(longint'(m_p01) + qmul(dt, m_p11));
        c   = clip32(longint'(m_p11) + longint'(m_qv));
        s   = clip32(longint'(a) + longint'(m_r));
        k0  = kgain(a, s);
        k1  = kgain(b, s);
        e   = clip32(longint'(z) - longint'(xp));
        omk = 65536 - longint'(k0);
        if (s == 0)
            n_zero_s++;
        m_x0  = clip32(longint'(xp) + qmul(k0, e));
        m_x1  = clip32(longint'(m_x1) + qmul(k1, e));
        m_p00 = clip32(qmul(omk, a));
        m_p01 = clip32(qmul(omk, b));
        m_p11 = clip32(longint'(c) - qmul(k1, b));
        if (m_p00 < 0)
            m_p00 = 0;
        if (m_p11 < 0)
            m_p11 = 0;
        r.pos   = m_x0;
        r.vel   = m_x1;
        r.innov = e;
        r.var_s = (s < 0) ? 31'd0 : s[30:0];
        r.innov_typed = typed_next;
        r.innov_given = typed_innov;
        expected_q.push_back(r);
    endtask

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // model update and result check
    always @(posedge clk)
    begin
        filter_out_t x;
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (cfg_write)
            begin
                case (cfg_index)
                    kpv_pkg::CFG_STEP_PERIOD:    m_dt = cfg_data[16:0];
                    kpv_pkg::CFG_POSITION_NOISE: m_qp = cfg_data;
                    kpv_pkg::CFG_VELOCITY_NOISE: m_qv = cfg_data;
                    kpv_pkg::CFG_MEASURE_NOISE:  m_r  = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                kalman_step(measured_position);
                n_items++;
            end
            if (out_valid && !out_stall)
            begin
                n_results++;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result item pos=%0d", $time, est_position);
                    n_err++;
                end
                else
                begin
                    x = expected_q.pop_front();
                    if (est_position !== x.pos)
                    begin
                        $display("%0t: est_position exp %0d got %0d", $time, x.pos,
                                 est_position);
                        n_err++;
                    end
                    if (est_velocity !== x.vel)
                    begin
                        $display("%0t: est_velocity exp %0d got %0d", $time, x.vel,
                                 est_velocity);
                        n_err++;
                    end
                    if (innovation_value !== x.innov)
                    begin
                        $display("%0t: innovation_value exp %0d got %0d", $time, x.innov,
                                 innovation_value);
                        n_err++;
                    end
                    if (x.innov_typed && innovation_value !== x.innov_given)
                    begin
                        $display("%0t: innovation_value exp %0d got %0d", $time,
                                 x.innov_given, innovation_value);
                        n_err++;
                    end
                    if (innovation_variance !== x.var_s)
                    begin
                        $display("%0t: innovation_variance exp %0d got %0d", $time,
                                 x.var_s, innovation_variance);
                        n_err++;
                    end
                end
            end
        end
    end

    // receiver stall pattern with one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (holdoff > 0)
        begin
            out_stall <= 1'b1;
            holdoff <= holdoff - 1;
        end
        else if (!holdoff_done && cycle_count > 30000)
        begin
            holdoff_done <= 1'b1;
            holdoff <= 600;
            out_stall <= 1'b1;
        end
        else if ((cycle_count / 4000) % 3 == 0)
            out_stall <= 1'b0;
        else if ((cycle_count / 4000) % 3 == 1)
            out_stall <= ($urandom_range(0, 3) == 0);
        else
            out_stall <= ($urandom_range(0, 1) == 0);
    end

    task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    int burst_left;

    task automatic send_item(input logic signed [31:0] z);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        in_valid = 1'b1;
        measured_position = z;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        @(negedge clk);
        typed_next = 1'b0;
        in_valid = 1'b0;
    endtask

    task automatic drain;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    function automatic logic [30:0] pick_noise(int mode);
        case (mode)
            0: return 31'd0;
            1: return 31'h7FFFFFFF;
            2: return 31'($urandom_range(0, 4096));
            default: return 31'($urandom) & 31'h7FFFFFFF;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_meas();
        int sel;
        logic signed [31:0] track;
        sel = $urandom_range(0, 9);
        track = m_x0 + m_x1;
        if (sel < 6)
            return track + 32'($signed($urandom_range(0, 8191)) - 4096);
        else if (sel < 8)
            return 32'($urandom);
        else if (sel == 8)
            return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
        else
            return 32'($signed($urandom_range(0, 2000000)) - 1000000);
    endfunction

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        measured_position = '0;
        cfg_write = 1'b0;
        cfg_index = kpv_pkg::CFG_STEP_PERIOD;
        cfg_data = '0;
        n_err = 0;
        n_items = 0;
        n_results = 0;
        n_zero_s = 0;
        cycle_count = 0;
        holdoff = 0;
        holdoff_done = 1'b0;
        burst_left = 0;
        typed_next = 1'b0;
        typed_innov = '0;
        m_dt = 17'd655;
        m_qp = 31'd655;
        m_qv = 31'd655;
        m_r  = 31'd65536;
        m_x0 = '0;
        m_x1 = '0;
        m_p00 = 32'sd65536;
        m_p01 = '0;
        m_p11 = 32'sd65536;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            typed_next  = directed_rows[i].typed;
            typed_innov = directed_rows[i].innov;
            send_item(directed_rows[i].z);
        end
        drain();

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(kpv_pkg::CFG_STEP_PERIOD, 31'd0);
                    write_reg(kpv_pkg::CFG_POSITION_NOISE, 31'd0);
                    write_reg(kpv_pkg::CFG_VELOCITY_NOISE, 31'd0);
                    write_reg(kpv_pkg::CFG_MEASURE_NOISE, 31'd0);
                end
                1:
                begin
                    write_reg(kpv_pkg::CFG_STEP_PERIOD, 31'h7FFFFFFF);
                    write_reg(kpv_pkg::CFG_POSITION_NOISE, 31'h7FFFFFFF);
                    write_reg(kpv_pkg::CFG_VELOCITY_NOISE, 31'h7FFFFFFF);
                    write_reg(kpv_pkg::CFG_MEASURE_NOISE, 31'h7FFFFFFF);
                end
                2:
                begin
                    write_reg(kpv_pkg::CFG_STEP_PERIOD, 31'd65536);
                    write_reg(kpv_pkg::CFG_POSITION_NOISE, 31'd655);
                    write_reg(kpv_pkg::CFG_VELOCITY_NOISE, 31'd655);
                    write_reg(kpv_pkg::CFG_MEASURE_NOISE, 31'd65536);
                end
                3:
                begin
                    write_reg(kpv_pkg::CFG_STEP_PERIOD, 31'd131071);
                    write_reg(kpv_pkg::CFG_POSITION_NOISE, 31'd0);
                    write_reg(kpv_pkg::CFG_VELOCITY_NOISE, 31'h7FFFFFFF);
                    write_reg(kpv_pkg::CFG_MEASURE_NOISE, 31'd1);
                end
                default:
                begin
                    write_reg(kpv_pkg::CFG_STEP_PERIOD, 31'($urandom));
                    write_reg(kpv_pkg::CFG_POSITION_NOISE, pick_noise($urandom_range(0, 3)));
                    write_reg(kpv_pkg::CFG_VELOCITY_NOISE, pick_noise($urandom_range(0, 3)));
                    write_reg(kpv_pkg::CFG_MEASURE_NOISE, pick_noise($urandom_range(0, 3)));
                end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_item(pick_meas());
            drain();
        end

        $display("Ran %0d measurements over %0d filter settings, %0d results checked,",
                 n_items, N_PHASES + 1, n_results);
        $display("%0d steps with zero innovation variance.", n_zero_s);
        if (n_err == 0 && expected_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Timeout waiting for results");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
